[rtl/pfs_pkg.sv]
// Package: shared constants, types and back-end state encoding for the prime filter sum unit.
package pfs_pkg;

   localparam int VALUE_BITS_DEF = 16;
   localparam int SUM_BITS       = 22;
   localparam logic [SUM_BITS-1:0] SUM_MAX = {SUM_BITS{1'b1}};
   localparam int QUEUE_DEPTH    = 4;
   localparam int FIRST_DIVISOR  = 3;

   // Verdict from the front end, carried with each value through the queue.
   typedef struct packed {
      logic last;
      logic trivial;        // verdict known without trial division
      logic trivial_prime;  // verdict when trivial
   } class_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DIV,
      ST_STEP,
      ST_DONE
   } back_state_type;

endpackage

[rtl/pfs_req_if.sv]
// Interface: input channel carrying one signed value and an end-of-set flag.
interface pfs_req_if #(
   parameter int VALUE_BITS = pfs_pkg::VALUE_BITS_DEF
);
   logic                         valid;
   logic                         ready;
   logic signed [VALUE_BITS-1:0] value;
   logic                         last;

   modport source (output valid, output value, output last, input ready);
   modport sink   (input valid, input value, input last, output ready);
endinterface

[rtl/pfs_rsp_if.sv]
// Interface: result channel carrying the prime flag, running sum and set-done flag.
interface pfs_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          is_prime;
   logic [pfs_pkg::SUM_BITS-1:0]  prime_sum;
   logic                          set_done;

   modport source (output valid, output is_prime, output prime_sum, output set_done,
                   input ready);
   modport sink   (input valid, input is_prime, input prime_sum, input set_done,
                   output ready);
endinterface

[rtl/prime_filter_sum_unit.sv]
// Top level: prime filter with running sum of primes per set.
//
//   channel    dir   handshake      payload
//   req_chan   in    valid/ready    value (signed VALUE_BITS), last
//   rsp_chan   out   valid/ready    is_prime, prime_sum (22 bits), set_done
//
// Negative, zero, one and even values skip trial division in the back end; an odd value
// is tried against k odd divisors (k up to about sqrt(v)/2), each on the bit-serial
// remainder unit, until one divides it or none is left below its square root.
// The front end takes one transfer per cycle while the 4-entry queue has room.
// Reset is synchronous: it empties the queue, clears the running sum and the result valid flag.
// A stalled result holds the back end in its final state; the queue keeps filling.
module prime_filter_sum_unit #(
   parameter int VALUE_BITS = pfs_pkg::VALUE_BITS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   pfs_req_if.sink      req_chan,
   pfs_rsp_if.source    rsp_chan
);

   localparam int CLS_BITS = $bits(pfs_pkg::class_type);
   localparam int Q_BITS   = VALUE_BITS + CLS_BITS;

   logic                  q_full;
   logic                  q_push;
   logic [VALUE_BITS-1:0] push_value;
   pfs_pkg::class_type    push_class;
   logic                  q_pop;
   logic                  q_valid;
   logic [Q_BITS-1:0]     q_data;
   logic [VALUE_BITS-1:0] pop_value;
   pfs_pkg::class_type    pop_class;

   assign pop_value = q_data[Q_BITS-1:CLS_BITS];
   assign pop_class = q_data[CLS_BITS-1:0];

   pfs_front #(
      .VALUE_BITS (VALUE_BITS)
   ) u_front (
      .req_chan (req_chan),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_value  (push_value),
      .q_class  (push_class)
   );

   pfs_queue #(
      .DATA_BITS (Q_BITS),
      .DEPTH     (pfs_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data ({push_value, push_class}),
      .full      (q_full),
      .pop       (q_pop),
      .pop_valid (q_valid),
      .pop_data  (q_data)
   );

   pfs_back #(
      .VALUE_BITS (VALUE_BITS)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .q_valid  (q_valid),
      .q_value  (pop_value),
      .q_class  (pop_class),
      .q_pop    (q_pop),
      .rsp_chan (rsp_chan)
   );

endmodule

[rtl/pfs_front.sv]
// Front end: accepts input transfers and classifies values that need no trial division.
module pfs_front #(
   parameter int VALUE_BITS = pfs_pkg::VALUE_BITS_DEF
) (
   pfs_req_if.sink                 req_chan,
   input  logic                    q_full,
   output logic                    q_push,
   output logic [VALUE_BITS-1:0]   q_value,
   output pfs_pkg::class_type      q_class
);

   logic negative;
   logic is_two;
   logic below_two;

   assign req_chan.ready = !q_full;
   assign q_push         = req_chan.valid && !q_full;
   assign q_value        = req_chan.value;

   assign negative  = req_chan.value[VALUE_BITS-1];
   assign is_two    = (req_chan.value == VALUE_BITS'(2));
   assign below_two = (req_chan.value[VALUE_BITS-1:1] == '0);

   // Negative, zero, one and even values are settled here; two is the only prime among them.
   always_comb begin
      q_class.last          = req_chan.last;
      q_class.trivial       = negative || below_two || !req_chan.value[0];
      q_class.trivial_prime = !negative && is_two;
   end

endmodule

[rtl/pfs_queue.sv]
// Queue: short FIFO between the front end and the trial-division back end.
module pfs_queue #(
   parameter int DATA_BITS = 8,
   parameter int DEPTH     = pfs_pkg::QUEUE_DEPTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  logic [DATA_BITS-1:0] push_data,
   output logic                 full,
   input  logic                 pop,
   output logic                 pop_valid,
   output logic [DATA_BITS-1:0] pop_data
);

   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   logic [DATA_BITS-1:0] slot_ff [DEPTH];
   logic [PTR_BITS-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0]  count_ff, count_in;
   logic                 do_push;
   logic                 do_pop;

   assign full      = (count_ff == CNT_BITS'(DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_data  = slot_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[rtl/pfs_back.sv]
// Back end: trial division on a bit-serial remainder unit, running sum and result register.
module pfs_back #(
   parameter int VALUE_BITS = pfs_pkg::VALUE_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    q_valid,
   input  logic [VALUE_BITS-1:0]   q_value,
   input  pfs_pkg::class_type      q_class,
   output logic                    q_pop,
   pfs_rsp_if.source               rsp_chan
);

   localparam int SB      = pfs_pkg::SUM_BITS;
   localparam int BIT_W   = $clog2(VALUE_BITS);
   localparam int SQ_W    = 2 * VALUE_BITS;
   localparam int ADD_W   = ((VALUE_BITS > SB) ? VALUE_BITS : SB) + 1;

   pfs_pkg::back_state_type state_ff, state_in;

   logic [VALUE_BITS-1:0] val_ff, val_in;
   logic                  last_ff, last_in;
   logic                  verdict_ff, verdict_in;
   logic [VALUE_BITS-1:0] div_ff, div_in;
   logic [SQ_W-1:0]       div_sq_ff, div_sq_in;
   logic [VALUE_BITS-1:0] rem_ff, rem_in;
   logic [BIT_W-1:0]      bit_ff, bit_in;
   logic [SB-1:0]         acc_ff, acc_in;

   logic                  out_valid_ff, out_valid_in;
   logic                  out_prime_ff, out_prime_in;
   logic [SB-1:0]         out_sum_ff, out_sum_in;
   logic                  out_done_ff, out_done_in;

   logic [VALUE_BITS:0]   shifted;
   logic [ADD_W-1:0]      total;
   logic [SB-1:0]         new_sum;
   logic                  out_free;

   assign rsp_chan.valid     = out_valid_ff;
   assign rsp_chan.is_prime  = out_prime_ff;
   assign rsp_chan.prime_sum = out_sum_ff;
   assign rsp_chan.set_done  = out_done_ff;

   assign out_free = !out_valid_ff || rsp_chan.ready;
   assign shifted  = {rem_ff, val_ff[bit_ff]};

   // Saturating add of this value when it turned out prime.
   always_comb begin
      total = ADD_W'(acc_ff);
      if (verdict_ff) begin
         total = ADD_W'(acc_ff) + ADD_W'(val_ff);
      end
      new_sum = (total > ADD_W'(pfs_pkg::SUM_MAX)) ? pfs_pkg::SUM_MAX : total[SB-1:0];
   end

   always_comb begin
      state_in     = state_ff;
      q_pop        = 1'b0;
      val_in       = val_ff;
      last_in      = last_ff;
      verdict_in   = verdict_ff;
      div_in       = div_ff;
      div_sq_in    = div_sq_ff;
      rem_in       = rem_ff;
      bit_in       = bit_ff;
      acc_in       = acc_ff;
      out_valid_in = out_valid_ff && !rsp_chan.ready;
      out_prime_in = out_prime_ff;
      out_sum_in   = out_sum_ff;
      out_done_in  = out_done_ff;

      unique case (state_ff)
         pfs_pkg::ST_IDLE: begin
            if (q_valid) begin
               q_pop      = 1'b1;
               val_in     = q_value;
               last_in    = q_class.last;
               verdict_in = q_class.trivial_prime;
               div_in     = VALUE_BITS'(pfs_pkg::FIRST_DIVISOR);
               div_sq_in  = SQ_W'(pfs_pkg::FIRST_DIVISOR * pfs_pkg::FIRST_DIVISOR);
               state_in   = q_class.trivial ? pfs_pkg::ST_DONE : pfs_pkg::ST_CHECK;
            end
         end
         pfs_pkg::ST_CHECK: begin
            // No divisor left below the square root: the value is prime.
            if (div_sq_ff > SQ_W'(val_ff)) begin
               verdict_in = 1'b1;
               state_in   = pfs_pkg::ST_DONE;
            end else begin
               rem_in   = '0;
               bit_in   = BIT_W'(VALUE_BITS - 1);
               state_in = pfs_pkg::ST_DIV;
            end
         end
         pfs_pkg::ST_DIV: begin
            // One restoring step per cycle, most significant bit first.
            if (shifted >= {1'b0, div_ff}) begin
               rem_in = VALUE_BITS'(shifted - {1'b0, div_ff});
            end else begin
               rem_in = shifted[VALUE_BITS-1:0];
            end
            if (bit_ff == '0) begin
               state_in = pfs_pkg::ST_STEP;
            end else begin
               bit_in = bit_ff - 1'b1;
            end
         end
         pfs_pkg::ST_STEP: begin
            if (rem_ff == '0) begin
               verdict_in = 1'b0;
               state_in   = pfs_pkg::ST_DONE;
            end else begin
               // Advance to the next odd divisor: (d+2)^2 = d^2 + 4d + 4.
               div_in    = div_ff + VALUE_BITS'(2);
               div_sq_in = div_sq_ff + SQ_W'({div_ff, 2'b00}) + SQ_W'(4);
               state_in  = pfs_pkg::ST_CHECK;
            end
         end
         pfs_pkg::ST_DONE: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_prime_in = verdict_ff;
               out_sum_in   = new_sum;
               out_done_in  = last_ff;
               acc_in       = last_ff ? '0 : new_sum;
               state_in     = pfs_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pfs_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pfs_pkg::ST_IDLE;
         acc_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         acc_ff       <= acc_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      val_ff       <= val_in;
      last_ff      <= last_in;
      verdict_ff   <= verdict_in;
      div_ff       <= div_in;
      div_sq_ff    <= div_sq_in;
      rem_ff       <= rem_in;
      bit_ff       <= bit_in;
      out_prime_ff <= out_prime_in;
      out_sum_ff   <= out_sum_in;
      out_done_ff  <= out_done_in;
   end

endmodule
